// File: src/nrtp_pkg.sv
// Shared types, constants and codes for the nested region time profiler.
package nrtp_pkg;

   localparam int STACK_DEPTH = 10;
   localparam int NUM_REGIONS = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam int LVL_W     = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int TYPE_IDX_W = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
   localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [0:0] {
      CSR_ENABLE = 1'b0
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_BEGIN = 2'd0,
      MODE_END   = 2'd1,
      MODE_READ  = 2'd2,
      MODE_NOP   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_OVERFLOW  = 3'd1,
      ST_UNDERFLOW = 3'd2,
      ST_DISABLED  = 3'd3,
      ST_BADTYPE   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_PUSH = 2'd1,
      OP_POP  = 2'd2,
      OP_READ = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  region_type;
      logic [31:0] time_now;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [47:0] count_value;
      logic [3:0]  stack_level;
   } rsp_type;

   // Classified command passed from the front end to the back end.
   typedef struct packed {
      op_type             op;
      status_type         status;
      logic [3:0]         region_type;
      logic [31:0]        time_now;
      logic [LVL_W-1:0]   level_before;
      logic [LVL_W-1:0]   level_after;
   } cmd_type;

endpackage

// File: src/nested_region_time_profiler.sv
// Top level of the nested region time profiler: CSR port, front end, queue, back end.
//
//   channel   direction  handshake                        payload
//   request   in         start & !busy                    req_data (mode, region_type, time_now)
//   response  out        rsp_strobe, one cycle, no stall  rsp_data (status, count_value, level)
//   csr       in/out     psel & penable & pwrite, APB     pwdata / prdata, enable at 0x0
//
// One request is accepted per cycle while busy is low; its response goes through the
// queue write, the stack stage, then the totals stage together with the output register.
// Stack push/pop and the elapsed-time subtract share the stack stage; the 48-bit
// total add is in the totals stage. busy rises only when the command queue is full,
// which never happens since the back end drains one command every cycle.
// Reset is synchronous: stack level, queue, valid bits of the totals and enable clear,
// so all totals read as zero with no clearing pass.
module nested_region_time_profiler (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  nrtp_pkg::req_type                 req_data,
   output logic                              rsp_strobe,
   output nrtp_pkg::rsp_type                 rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [nrtp_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [nrtp_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [nrtp_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   logic              enable_ff;
   logic              csr_write;
   logic              accept;
   logic              cmd_write;
   nrtp_pkg::cmd_type cmd_in;
   logic              q_full;
   logic              q_valid;
   nrtp_pkg::cmd_type q_cmd;

   // Register index is the word address; byte offset bits are ignored.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == nrtp_pkg::CSR_ENABLE)
                      ? {{(nrtp_pkg::CSR_DATA_W-1){1'b0}}, enable_ff}
                      : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else if (csr_write && paddr[2] == nrtp_pkg::CSR_ENABLE) begin
         enable_ff <= pwdata[0];
      end
   end

   // Hold off new requests only while the queue is full.
   assign busy   = q_full;
   assign accept = start && !busy;

   nrtp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .enable    (enable_ff),
      .cmd_write (cmd_write),
      .cmd       (cmd_in)
   );

   nrtp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (cmd_write),
      .wr_data  (cmd_in),
      .full     (q_full),
      .rd_valid (q_valid),
      .rd_data  (q_cmd)
   );

   // Drain one command per cycle; the response side never stalls.
   nrtp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_valid),
      .cmd        (q_cmd),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// File: src/nrtp_front.sv
// Front end: classify each request and track the stack level.
module nrtp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  nrtp_pkg::req_type req_data,
   input  logic             enable,
   output logic             cmd_write,
   output nrtp_pkg::cmd_type cmd
);

   logic [nrtp_pkg::LVL_W-1:0] level_ff;
   logic [nrtp_pkg::LVL_W-1:0] level_in;
   logic                       bad_type;

   assign bad_type = (32'(req_data.region_type) >= nrtp_pkg::NUM_REGIONS);

   always_comb begin
      cmd.op           = nrtp_pkg::OP_NONE;
      cmd.status       = nrtp_pkg::ST_OK;
      cmd.region_type  = req_data.region_type;
      cmd.time_now     = req_data.time_now;
      cmd.level_before = level_ff;
      level_in         = level_ff;
      unique case (nrtp_pkg::mode_type'(req_data.mode))
         nrtp_pkg::MODE_BEGIN: begin
            if (!enable) begin
               cmd.status = nrtp_pkg::ST_DISABLED;
            end else if (32'(level_ff) >= nrtp_pkg::STACK_DEPTH) begin
               cmd.status = nrtp_pkg::ST_OVERFLOW;
            end else if (bad_type) begin
               cmd.status = nrtp_pkg::ST_BADTYPE;
            end else begin
               cmd.op   = nrtp_pkg::OP_PUSH;
               level_in = level_ff + nrtp_pkg::LVL_W'(1);
            end
         end
         nrtp_pkg::MODE_END: begin
            if (!enable) begin
               cmd.status = nrtp_pkg::ST_DISABLED;
            end else if (level_ff == '0) begin
               cmd.status = nrtp_pkg::ST_UNDERFLOW;
            end else begin
               cmd.op   = nrtp_pkg::OP_POP;
               level_in = level_ff - nrtp_pkg::LVL_W'(1);
            end
         end
         nrtp_pkg::MODE_READ: begin
            if (bad_type) begin
               cmd.status = nrtp_pkg::ST_BADTYPE;
            end else begin
               cmd.op = nrtp_pkg::OP_READ;
            end
         end
         default: begin
            cmd.op = nrtp_pkg::OP_NONE;
         end
      endcase
      cmd.level_after = level_in;
   end

   assign cmd_write = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else if (accept) begin
         level_ff <= level_in;
      end
   end

endmodule

// File: src/nrtp_queue.sv
// Short command queue between the front end and the back end.
module nrtp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  nrtp_pkg::cmd_type wr_data,
   output logic              full,
   output logic              rd_valid,
   output nrtp_pkg::cmd_type rd_data
);

   nrtp_pkg::cmd_type             mem_ff [nrtp_pkg::QUEUE_DEPTH];
   logic [nrtp_pkg::QPTR_W-1:0]   wr_ptr_ff;
   logic [nrtp_pkg::QPTR_W-1:0]   rd_ptr_ff;
   logic [nrtp_pkg::QCNT_W-1:0]   count_ff;
   logic                          rd_en;

   assign full     = (32'(count_ff) == nrtp_pkg::QUEUE_DEPTH);
   assign rd_valid = (count_ff != '0);
   assign rd_en    = rd_valid;
   assign rd_data  = mem_ff[rd_ptr_ff];

   function automatic logic [nrtp_pkg::QPTR_W-1:0] next_ptr(
      input logic [nrtp_pkg::QPTR_W-1:0] ptr);
      logic [nrtp_pkg::QPTR_W-1:0] res;
      if (32'(ptr) == nrtp_pkg::QUEUE_DEPTH - 1) begin
         res = '0;
      end else begin
         res = ptr + nrtp_pkg::QPTR_W'(1);
      end
      return res;
   endfunction

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (rd_en) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (wr_en && !rd_en) begin
            count_ff <= count_ff + nrtp_pkg::QCNT_W'(1);
         end else if (!wr_en && rd_en) begin
            count_ff <= count_ff - nrtp_pkg::QCNT_W'(1);
         end
      end
   end

`ifndef SYNTHESIS
   a_no_write_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !wr_en || rd_en)
      else $error("queue written while full");
`endif

endmodule

// File: src/nrtp_back.sv
// Back end: region stack, elapsed-time charging and per-region totals.
module nrtp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  nrtp_pkg::cmd_type cmd,
   output logic              rsp_strobe,
   output nrtp_pkg::rsp_type rsp_data
);

   // Stage 1: stack
   logic [3:0]  types_ff  [nrtp_pkg::STACK_DEPTH];
   logic [31:0] starts_ff [nrtp_pkg::STACK_DEPTH];

   logic [nrtp_pkg::IDX_W-1:0] top_idx;
   logic [nrtp_pkg::IDX_W-1:0] push_idx;
   logic [nrtp_pkg::IDX_W-1:0] below_idx;
   logic                       charge_in;

   logic                              s1_valid_ff;
   nrtp_pkg::op_type                  s1_op_ff;
   nrtp_pkg::status_type              s1_status_ff;
   logic                              s1_charge_ff;
   logic [nrtp_pkg::TYPE_IDX_W-1:0]   s1_addr_ff;
   logic [31:0]                       s1_diff_ff;
   logic [nrtp_pkg::LVL_W-1:0]        s1_level_ff;

   // Stage 2: totals
   logic [47:0]                  totals_ff [nrtp_pkg::NUM_REGIONS];
   logic [nrtp_pkg::NUM_REGIONS-1:0] totals_vld_ff;
   logic [47:0]                  total_rd;

   logic              rsp_strobe_ff;
   nrtp_pkg::rsp_type rsp_data_ff;

   assign top_idx   = nrtp_pkg::IDX_W'(cmd.level_before - nrtp_pkg::LVL_W'(1));
   assign push_idx  = nrtp_pkg::IDX_W'(cmd.level_before);
   assign below_idx = nrtp_pkg::IDX_W'(cmd.level_before - nrtp_pkg::LVL_W'(2));
   assign charge_in = ((cmd.op == nrtp_pkg::OP_PUSH) || (cmd.op == nrtp_pkg::OP_POP))
                      && (cmd.level_before != '0);

   always_ff @(posedge clock) begin
      if (cmd_valid && cmd.op == nrtp_pkg::OP_PUSH) begin
         types_ff[push_idx]  <= cmd.region_type;
         starts_ff[push_idx] <= cmd.time_now;
      end else if (cmd_valid && cmd.op == nrtp_pkg::OP_POP
                   && cmd.level_before > nrtp_pkg::LVL_W'(1)) begin
         // restart the timer of the region beneath
         starts_ff[below_idx] <= cmd.time_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd_valid;
      end
      s1_op_ff     <= cmd.op;
      s1_status_ff <= cmd.status;
      s1_charge_ff <= charge_in;
      s1_addr_ff   <= charge_in ? nrtp_pkg::TYPE_IDX_W'(types_ff[top_idx])
                                : nrtp_pkg::TYPE_IDX_W'(cmd.region_type);
      s1_diff_ff   <= cmd.time_now - starts_ff[top_idx];
      s1_level_ff  <= cmd.level_after;
   end

   assign total_rd = totals_vld_ff[s1_addr_ff] ? totals_ff[s1_addr_ff] : 48'd0;

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_charge_ff) begin
         totals_ff[s1_addr_ff] <= total_rd + 48'(s1_diff_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         totals_vld_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (s1_valid_ff && s1_charge_ff) begin
            totals_vld_ff[s1_addr_ff] <= 1'b1;
         end
         rsp_strobe_ff <= s1_valid_ff;
      end
      rsp_data_ff.status      <= s1_status_ff;
      rsp_data_ff.count_value <= (s1_op_ff == nrtp_pkg::OP_READ) ? total_rd : 48'd0;
      rsp_data_ff.stack_level <= 4'(s1_level_ff);
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

`ifndef SYNTHESIS
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_valid && cmd.op == nrtp_pkg::OP_POP |-> cmd.level_before != '0)
      else $error("pop issued on an empty stack");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd_valid && cmd.op == nrtp_pkg::OP_PUSH
      |-> 32'(cmd.level_before) < nrtp_pkg::STACK_DEPTH)
      else $error("push issued on a full stack");
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      cmd_valid |-> ##2 rsp_strobe)
      else $error("command produced no response");
`endif

endmodule
